// File: rtl/sul_pkg.sv
// sul_pkg: word types, status and mode codes for the sorted unique list insert unit
// no dependencies; used by sorted_unique_list_insert_unit
`default_nettype none

package sul_pkg;

	localparam int CAPACITY = 64;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [2:0] STAT_INSERTED = 3'd0;
	localparam logic [2:0] STAT_DUP      = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_CLEARED  = 3'd3;
	localparam logic [2:0] STAT_READ_OK  = 3'd4;
	localparam logic [2:0] STAT_BEYOND   = 3'd5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] value;
		logic [5:0]  index;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  position;
		logic [31:0] entry_value;
		logic [6:0]  entry_count;
	} out_word_t;

endpackage

`default_nettype wire

// File: rtl/sul_ram.sv
// sul_ram: simple dual-port list memory, one write and one registered read per cycle
// no package dependencies; instantiated by sorted_unique_list_insert_unit
`default_nettype none

module sul_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/sorted_unique_list_insert_unit.sv
// sorted_unique_list_insert_unit: ascending list of distinct words with clear, insert, read
// depends on sul_pkg (word types, codes) and sul_ram (list memory)
// done strobe: clear and read past the count from idle, read from S_READ, insert from S_SEARCH
// (one entry per cycle up to the first entry not less than the value), S_RESOLVE (dup or full
// stops), S_SHIFT (down from the top); one word at a time, busy drops with the done strobe
// reset: clears the entry count and the controller; list memory is not cleared
`default_nettype none

module sorted_unique_list_insert_unit #(
	parameter int CAPACITY = sul_pkg::CAPACITY
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	input  wire sul_pkg::in_word_t item,
	output      logic              done,
	output      sul_pkg::out_word_t result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SEARCH  = 3'd1;
	localparam logic [2:0] S_RESOLVE = 3'd2;
	localparam logic [2:0] S_SHIFT   = 3'd3;
	localparam logic [2:0] S_READ    = 3'd4;

	logic [2:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      ptr_q;
	logic [CW-1:0]      pos_q;
	logic               pend_q;
	logic               dup_q;
	logic [31:0]        value_q;
	logic [5:0]         idx_q;
	logic [AW-1:0]      raddr_s1;
	logic               done_q;
	sul_pkg::out_word_t result_q;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [31:0]        rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [31:0]        wr_data;
	logic               accept;
	logic               in_range;
	logic               hit;
	logic               eq;
	logic [CW-1:0]      cnt_inc;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign in_range = XW'(item.index) < XW'(cnt_q);
	// shared compare unit
	assign eq      = (rd_data == value_q);
	assign hit     = pend_q && ((rd_data > value_q) || eq);
	assign cnt_inc = cnt_q + CW'(1);
	assign done    = done_q;
	assign result  = result_q;

	sul_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(32)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(ptr_q);
		wr_en   = 1'b0;
		wr_addr = AW'(pos_q);
		wr_data = value_q;
		case (state_q)
			S_IDLE: begin
				if (accept && item.mode[1] && in_range) begin
					rd_en   = 1'b1;
					rd_addr = AW'(item.index);
				end
			end
			S_SEARCH: begin
				if (!hit && (ptr_q != cnt_q)) begin
					rd_en   = 1'b1;
					rd_addr = AW'(ptr_q);
				end
			end
			S_SHIFT: begin
				if (pend_q) begin
					wr_en   = 1'b1;
					wr_addr = raddr_s1 + AW'(1);
					wr_data = rd_data;
				end else if (ptr_q == pos_q) begin
					wr_en   = 1'b1;
					wr_addr = AW'(pos_q);
					wr_data = value_q;
				end
				if (ptr_q != pos_q) begin
					rd_en   = 1'b1;
					rd_addr = AW'(ptr_q - CW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= item.index;
						value_q <= item.value;
						ptr_q   <= '0;
						pend_q  <= 1'b0;
						if (item.mode == sul_pkg::MODE_CLEAR) begin
							cnt_q                <= '0;
							done_q               <= 1'b1;
							result_q.status      <= sul_pkg::STAT_CLEARED;
							result_q.position    <= '0;
							result_q.entry_value <= '0;
							result_q.entry_count <= '0;
						end else if (item.mode[1]) begin
							if (in_range) begin
								state_q <= S_READ;
							end else begin
								done_q               <= 1'b1;
								result_q.status      <= sul_pkg::STAT_BEYOND;
								result_q.position    <= 7'(item.index);
								result_q.entry_value <= '0;
								result_q.entry_count <= 7'(cnt_q);
							end
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						pos_q   <= CW'(raddr_s1);
						dup_q   <= eq;
						pend_q  <= 1'b0;
						state_q <= S_RESOLVE;
					end else if (ptr_q == cnt_q) begin
						pos_q   <= cnt_q;
						dup_q   <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= S_RESOLVE;
					end else begin
						raddr_s1 <= rd_addr;
						ptr_q    <= ptr_q + CW'(1);
						pend_q   <= 1'b1;
					end
				end
				S_RESOLVE: begin
					if (dup_q || (cnt_q == CW'(CAPACITY))) begin
						done_q               <= 1'b1;
						result_q.status      <= dup_q ? sul_pkg::STAT_DUP : sul_pkg::STAT_FULL;
						result_q.position    <= 7'(pos_q);
						result_q.entry_value <= '0;
						result_q.entry_count <= 7'(cnt_q);
						state_q              <= S_IDLE;
					end else begin
						ptr_q   <= cnt_q;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (ptr_q != pos_q) begin
						raddr_s1 <= rd_addr;
						ptr_q    <= ptr_q - CW'(1);
						pend_q   <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						cnt_q                <= cnt_inc;
						done_q               <= 1'b1;
						result_q.status      <= sul_pkg::STAT_INSERTED;
						result_q.position    <= 7'(pos_q);
						result_q.entry_value <= '0;
						result_q.entry_count <= 7'(cnt_inc);
						state_q              <= S_IDLE;
					end
				end
				S_READ: begin
					done_q               <= 1'b1;
					result_q.status      <= sul_pkg::STAT_READ_OK;
					result_q.position    <= 7'(idx_q);
					result_q.entry_value <= rd_data;
					result_q.entry_count <= 7'(cnt_q);
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
